### hdl/rgba_color_transform_top_defines.svh
// Assertion macros shared by the checker of the RGBA color transform.
// Depends on nothing; included by the checker file by its bare name.
`ifndef RGBA_COLOR_TRANSFORM_TOP_DEFINES_SVH
`define RGBA_COLOR_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rct assertion failed");

// Next-cycle implication that is also checked across reset.
`define RCT_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rct assertion failed");

`endif

### hdl/rct_pkg.sv
// Shared types and constants of the RGBA color transform.
// Depends on nothing; used by every module of the block.
package rct_pkg;

  localparam int CH_NUM     = 4;
  localparam int COLOR_NUM  = 3;
  localparam int CH_ALPHA   = 3;
  localparam int PIX_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int OFS_W      = 9;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = PIX_W + 1 + GAIN_W;
  localparam int SCALED_W   = PROD_W + 1;
  localparam int CLAMP_W    = 24;
  localparam int WPROD_W    = CLAMP_W + PIX_W;
  localparam int QUOT_W     = WPROD_W - FRAC_W;
  localparam int STAGES     = 4;

  localparam logic [PIX_W-1:0]   ALPHA_MAX  = 8'd255;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'd256;
  localparam logic [CLAMP_W-1:0] S_LIMIT    = 24'd16646400;
  localparam logic [QUOT_W-1:0]  T_LIMIT    = 24'd65280;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_GAIN     = 3'd0,
    REG_GREEN_GAIN   = 3'd1,
    REG_BLUE_GAIN    = 3'd2,
    REG_ALPHA_GAIN   = 3'd3,
    REG_RED_OFFSET   = 3'd4,
    REG_GREEN_OFFSET = 3'd5,
    REG_BLUE_OFFSET  = 3'd6,
    REG_ALPHA_OFFSET = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_NUM-1:0][GAIN_W-1:0] gain;
    logic [CH_NUM-1:0][OFS_W-1:0]  ofs;
    logic                          ident;
  } cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] adv;
  } flow_t;

endpackage

### hdl/rgba_color_transform_top.sv
// Top level of the RGBA color transform with alpha weighting.
// Depends on rct_pkg, rct_regs, rct_flow and rct_datapath.
//
// Pixels enter on the input channel (in_valid, in_stall) with the four
// channel bytes and last_in, and leave on the output channel (out_valid,
// out_stall) with the transformed bytes and last_out, one result per
// transaction and in order.
// The pipeline has four register stages: scale and offset, clamp, alpha
// multiply, divide by 255 with saturation. An accepted input transaction
// passes through them in that order to out_valid, and one pixel is taken every
// cycle while the output is not stalled.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it keep filling their empty slots; in_stall rises only
// once every stage holds a pixel.
// Reset clears all valid bits, sets every gain to 1.0 and every offset
// to zero, so the block then passes pixels through unchanged.
// The user writes registers through cfg_write, cfg_index and cfg_data only
// while no transaction is in flight; the block itself does not enforce it.
module rgba_color_transform_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rct_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rct_pkg::PIX_W-1:0]       red_in,
  input  logic [rct_pkg::PIX_W-1:0]       green_in,
  input  logic [rct_pkg::PIX_W-1:0]       blue_in,
  input  logic [rct_pkg::PIX_W-1:0]       alpha_in,
  input  logic                            last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rct_pkg::PIX_W-1:0]       red_out,
  output logic [rct_pkg::PIX_W-1:0]       green_out,
  output logic [rct_pkg::PIX_W-1:0]       blue_out,
  output logic [rct_pkg::PIX_W-1:0]       alpha_out,
  output logic                            last_out
);
  import rct_pkg::*;

  cfg_t                          cfg;
  flow_t                         flow;
  logic [CH_NUM-1:0][PIX_W-1:0]  pix_in;
  logic [CH_NUM-1:0][PIX_W-1:0]  pix_out;

  assign pix_in = {alpha_in, blue_in, green_in, red_in};

  rct_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rct_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flow      (flow)
  );

  rct_datapath u_datapath (
    .clk      (clk),
    .flow     (flow),
    .cfg      (cfg),
    .pix_in   (pix_in),
    .last_in  (last_in),
    .pix_out  (pix_out),
    .last_out (last_out)
  );

  assign red_out   = pix_out[0];
  assign green_out = pix_out[1];
  assign blue_out  = pix_out[2];
  assign alpha_out = pix_out[CH_ALPHA];

endmodule

### hdl/rct_regs.sv
// Configuration registers of the RGBA color transform and the identity flag.
// Depends on rct_pkg.
module rct_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rct_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rct_pkg::cfg_t                   cfg
);
  import rct_pkg::*;

  logic [CH_NUM-1:0][GAIN_W-1:0] gain;
  logic [CH_NUM-1:0][OFS_W-1:0]  ofs;
  logic                          ident;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH_NUM; i++) begin
        gain[i] <= UNITY_GAIN;
        ofs[i]  <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_RED_GAIN:     gain[0] <= cfg_data[GAIN_W-1:0];
        REG_GREEN_GAIN:   gain[1] <= cfg_data[GAIN_W-1:0];
        REG_BLUE_GAIN:    gain[2] <= cfg_data[GAIN_W-1:0];
        REG_ALPHA_GAIN:   gain[3] <= cfg_data[GAIN_W-1:0];
        REG_RED_OFFSET:   ofs[0]  <= cfg_data[OFS_W-1:0];
        REG_GREEN_OFFSET: ofs[1]  <= cfg_data[OFS_W-1:0];
        REG_BLUE_OFFSET:  ofs[2]  <= cfg_data[OFS_W-1:0];
        REG_ALPHA_OFFSET: ofs[3]  <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ident = 1'b1;
    for (int i = 0; i < CH_NUM; i++) begin
      if (gain[i] != UNITY_GAIN || ofs[i] != '0) begin
        ident = 1'b0;
      end
    end
  end

  assign cfg.gain  = gain;
  assign cfg.ofs   = ofs;
  assign cfg.ident = ident;

endmodule

### hdl/rct_flow.sv
// Valid bits and stage advance enables of the four-stage pipeline.
// Depends on rct_pkg.
module rct_flow (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output rct_pkg::flow_t flow
);
  import rct_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;
  logic [STAGES-1:0] adv;

  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vld_next = {vld[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_next[k];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[STAGES-1];
  assign flow.adv  = adv;

endmodule

### hdl/rct_datapath.sv
// Arithmetic stages: scale and offset, clamp, alpha multiply, divide by 255.
// Depends on rct_pkg; advanced by the enables from rct_flow.
module rct_datapath (
  input  logic                                        clk,
  input  rct_pkg::flow_t                              flow,
  input  rct_pkg::cfg_t                               cfg,
  input  logic [rct_pkg::CH_NUM-1:0][rct_pkg::PIX_W-1:0] pix_in,
  input  logic                                        last_in,
  output logic [rct_pkg::CH_NUM-1:0][rct_pkg::PIX_W-1:0] pix_out,
  output logic                                        last_out
);
  import rct_pkg::*;

  logic signed [PROD_W-1:0]   prod     [CH_NUM];
  logic signed [SCALED_W-1:0] s1_next  [CH_NUM];
  logic signed [SCALED_W-1:0] s1       [CH_NUM];
  pix_t                       raw1     [CH_NUM];
  logic                       last1;

  logic [CLAMP_W-1:0]         c2_next  [COLOR_NUM];
  logic [CLAMP_W-1:0]         c2       [COLOR_NUM];
  pix_t                       na2_next;
  pix_t                       na2;
  pix_t                       raw2     [CH_NUM];
  logic                       last2;

  logic [WPROD_W-1:0]         wprod    [COLOR_NUM];
  logic [QUOT_W-1:0]          t3       [COLOR_NUM];
  pix_t                       na3;
  pix_t                       raw3     [CH_NUM];
  logic                       last3;

  logic [QUOT_W-1:0]          qsum     [COLOR_NUM];
  pix_t                       q4_next  [CH_NUM];
  pix_t                       pix4     [CH_NUM];
  logic                       last4;

  always_comb begin
    for (int i = 0; i < CH_NUM; i++) begin
      prod[i]    = $signed({1'b0, pix_in[i]}) * $signed(cfg.gain[i]);
      s1_next[i] = SCALED_W'(prod[i]) + SCALED_W'($signed({cfg.ofs[i], 8'h00}));
    end
  end

  always_ff @(posedge clk) begin
    if (flow.adv[0]) begin
      for (int i = 0; i < CH_NUM; i++) begin
        s1[i]   <= s1_next[i];
        raw1[i] <= pix_in[i];
      end
      last1 <= last_in;
    end
  end

  always_comb begin
    if (s1[CH_ALPHA][SCALED_W-1]) begin
      na2_next = '0;
    end else if (|s1[CH_ALPHA][SCALED_W-2:2*FRAC_W]) begin
      na2_next = ALPHA_MAX;
    end else begin
      na2_next = s1[CH_ALPHA][2*FRAC_W-1:FRAC_W];
    end
    for (int i = 0; i < COLOR_NUM; i++) begin
      if (s1[i][SCALED_W-1]) begin
        c2_next[i] = '0;
      end else if (s1[i][SCALED_W-2:0] >= (SCALED_W-1)'(S_LIMIT)) begin
        c2_next[i] = S_LIMIT;
      end else begin
        c2_next[i] = s1[i][CLAMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flow.adv[1]) begin
      for (int i = 0; i < COLOR_NUM; i++) begin
        c2[i] <= c2_next[i];
      end
      for (int i = 0; i < CH_NUM; i++) begin
        raw2[i] <= raw1[i];
      end
      na2   <= na2_next;
      last2 <= last1;
    end
  end

  always_comb begin
    for (int i = 0; i < COLOR_NUM; i++) begin
      wprod[i] = WPROD_W'(c2[i]) * WPROD_W'(na2);
    end
  end

  always_ff @(posedge clk) begin
    if (flow.adv[2]) begin
      for (int i = 0; i < COLOR_NUM; i++) begin
        t3[i] <= wprod[i][WPROD_W-1:FRAC_W];
      end
      for (int i = 0; i < CH_NUM; i++) begin
        raw3[i] <= raw2[i];
      end
      na3   <= na2;
      last3 <= last2;
    end
  end

  // Below the limit, (t + t/256 + 1) / 256 is exactly t / 255.
  always_comb begin
    for (int i = 0; i < COLOR_NUM; i++) begin
      qsum[i] = t3[i] + QUOT_W'(t3[i][2*FRAC_W-1:FRAC_W]) + QUOT_W'(1);
      if (cfg.ident) begin
        q4_next[i] = raw3[i];
      end else if (t3[i] >= T_LIMIT) begin
        q4_next[i] = ALPHA_MAX;
      end else begin
        q4_next[i] = qsum[i][2*FRAC_W-1:FRAC_W];
      end
    end
    q4_next[CH_ALPHA] = cfg.ident ? raw3[CH_ALPHA] : na3;
  end

  always_ff @(posedge clk) begin
    if (flow.adv[3]) begin
      for (int i = 0; i < CH_NUM; i++) begin
        pix4[i] <= q4_next[i];
      end
      last4 <= last3;
    end
  end

  always_comb begin
    for (int i = 0; i < CH_NUM; i++) begin
      pix_out[i] = pix4[i];
    end
  end

  assign last_out = last4;

endmodule

### hdl/rgba_color_transform_chk.sv
// Port-level checker of the RGBA color transform, bound to the top level.
// Depends on rct_pkg and rgba_color_transform_top_defines.svh.
`include "rgba_color_transform_top_defines.svh"

module rgba_color_transform_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rct_pkg::PIX_W-1:0]       red_out,
  input logic [rct_pkg::PIX_W-1:0]       green_out,
  input logic [rct_pkg::PIX_W-1:0]       blue_out,
  input logic [rct_pkg::PIX_W-1:0]       alpha_out,
  input logic                            last_out
);
  import rct_pkg::*;

  `RCT_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)

  `RCT_ASSERT_IMPL(a_stall_needs_full, clk, rst, in_stall, out_valid && out_stall)

  `RCT_ASSERT_IMPL(a_latency, clk, rst,
    $past(in_valid && !in_stall, 4) && !$past(out_stall, 1) &&
    !$past(out_stall, 2) && !$past(out_stall, 3) && !$past(rst, 1) &&
    !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4),
    out_valid)

  `RCT_ASSERT_IMPL(a_out_hold, clk, rst,
    $past(out_valid && out_stall) && !$past(rst),
    out_valid && $stable(red_out) && $stable(green_out) &&
    $stable(blue_out) && $stable(alpha_out) && $stable(last_out))

endmodule

bind rgba_color_transform_top rgba_color_transform_chk u_chk (.*);
